[design/jpeg_huffman_coefficient_decoder_macros.svh]
// Assertion macros shared by the decoder RTL.
// Every macro assumes a clock named clk_i and an active-low reset named rst_ni.
`ifndef JPEG_HUFFMAN_COEFFICIENT_DECODER_MACROS_SVH
`define JPEG_HUFFMAN_COEFFICIENT_DECODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JHD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define JHD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/jhd_pkg.sv]
// Shared types and constants for the JPEG Huffman coefficient decoder.
// Has no dependencies; it is used by jhd_code_table and by the top level.
package jhd_pkg;

  localparam int MAX_CODE_LENGTH = 16;
  localparam int AC_COEFFICIENTS = 63;
  localparam int ENTRY_W         = 28;

  // Input item kinds.
  localparam logic [1:0] KIND_APPEND = 2'd0;
  localparam logic [1:0] KIND_SCAN   = 2'd1;
  localparam logic [1:0] KIND_START  = 2'd2;
  localparam logic [1:0] KIND_CLEAR  = 2'd3;

  // Result kinds.
  localparam logic [1:0] RK_DC  = 2'd0;
  localparam logic [1:0] RK_AC  = 2'd1;
  localparam logic [1:0] RK_EOB = 2'd2;
  localparam logic [1:0] RK_ERR = 2'd3;

  // Error codes.
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_NO_CODE = 2'd1;
  localparam logic [1:0] ERR_BAD_AC  = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_COMPONENT_COUNT = 3'd0;
  localparam logic [2:0] CFG_BLOCKS_FIRST    = 3'd1;
  localparam logic [2:0] CFG_BLOCKS_SECOND   = 3'd2;
  localparam logic [2:0] CFG_BLOCKS_THIRD    = 3'd3;
  localparam logic [2:0] CFG_TABLE_SELECTION = 3'd4;

  typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_SEARCH, ST_EMIT} st_e;
  typedef enum logic [1:0] {PH_DC_SYM, PH_DC_MAG, PH_AC_SYM, PH_AC_MAG} ph_e;

  // Table maintenance command from the sequencer.
  typedef struct packed {
    logic        append;
    logic        clear;
    logic [1:0]  tab;
    logic [4:0]  len;
    logic [15:0] bits;
    logic [7:0]  sym;
  } tbl_cmd_t;

  // Search request and response.
  typedef struct packed {
    logic        start;
    logic [1:0]  tab;
    logic [15:0] acc;
    logic [4:0]  seen;
  } srch_req_t;

  typedef struct packed {
    logic       done;
    logic       found;
    logic [7:0] sym;
  } srch_rsp_t;

  // One result transaction.
  typedef struct packed {
    logic [1:0]         kind;
    logic [1:0]         comp;
    logic [3:0]         blk;
    logic [5:0]         pos;
    logic [3:0]         run;
    logic [3:0]         size;
    logic signed [15:0] value;
    logic signed [15:0] dcv;
    logic [1:0]         err;
    logic               done;
  } res_t;

endpackage

[design/jhd_code_table.sv]
// Code table store with a sequential matcher: one entry compared per cycle.
// Depends on jhd_pkg.
module jhd_code_table #(
  parameter int CODES_PER_TABLE = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  jhd_pkg::tbl_cmd_t   cmd_i,
  input  jhd_pkg::srch_req_t  req_i,
  output jhd_pkg::srch_rsp_t  rsp_o
);
  import jhd_pkg::*;

  localparam int CW    = $clog2(CODES_PER_TABLE + 1);
  localparam int DEPTH = 4 * CODES_PER_TABLE;
  localparam int AW    = $clog2(DEPTH);

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [CW-1:0]      count_q [4];
  logic [CW-1:0]      idx_q, idx_d;
  logic               busy_q, busy_d;
  logic               pend_q, pend_d;
  logic [1:0]         tab_q, tab_d;
  logic [15:0]        acc_q, acc_d;
  logic [4:0]         seen_q, seen_d;
  logic [ENTRY_W-1:0] rd_data_q;

  logic          wr_ok, more, issue, hit, done;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [CW-1:0] cur_cnt;

  assign cur_cnt = count_q[tab_q];
  assign wr_ok   = cmd_i.append && (cmd_i.len >= 5'd1) && (cmd_i.len <= 5'd16) &&
                   (count_q[cmd_i.tab] < CW'(CODES_PER_TABLE));
  assign wr_addr = AW'(cmd_i.tab) * AW'(CODES_PER_TABLE) + AW'(count_q[cmd_i.tab]);
  assign rd_addr = AW'(tab_q) * AW'(CODES_PER_TABLE) + AW'(idx_q);

  assign hit   = busy_q && pend_q &&
                 (({1'b0, rd_data_q[27:24]} + 5'd1) == seen_q) &&
                 (rd_data_q[23:8] == acc_q);
  assign more  = idx_q < cur_cnt;
  assign done  = busy_q && (hit || !more);
  assign issue = busy_q && more && !hit;

  assign rsp_o.done  = done;
  assign rsp_o.found = hit;
  assign rsp_o.sym   = rd_data_q[7:0];

  always_comb begin
    busy_d = busy_q;
    pend_d = issue;
    idx_d  = idx_q;
    tab_d  = tab_q;
    acc_d  = acc_q;
    seen_d = seen_q;
    if (issue) begin
      idx_d = idx_q + CW'(1);
    end
    if (done) begin
      busy_d = 1'b0;
    end
    if (req_i.start && !busy_q) begin
      busy_d = 1'b1;
      pend_d = 1'b0;
      idx_d  = '0;
      tab_d  = req_i.tab;
      acc_d  = req_i.acc;
      seen_d = req_i.seen;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pend_q <= 1'b0;
      idx_q  <= '0;
      for (int i = 0; i < 4; i++) begin
        count_q[i] <= '0;
      end
    end else begin
      busy_q <= busy_d;
      pend_q <= pend_d;
      idx_q  <= idx_d;
      if (wr_ok) begin
        count_q[cmd_i.tab] <= count_q[cmd_i.tab] + CW'(1);
      end else if (cmd_i.clear) begin
        count_q[cmd_i.tab] <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tab_q  <= tab_d;
    acc_q  <= acc_d;
    seen_q <= seen_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      mem[wr_addr] <= {cmd_i.len[3:0] - 4'd1, cmd_i.bits, cmd_i.sym};
    end
    if (issue) begin
      rd_data_q <= mem[rd_addr];
    end
  end

endmodule

[design/jpeg_huffman_coefficient_decoder.sv]
// Baseline JPEG Huffman coefficient decoder, top level with the sequencer.
// Depends on jhd_pkg, jhd_code_table and the assertion macro header.
//
// Usage: the input channel (in_valid_i/in_ready_o) carries one transaction
// per item: a table append, a table clear, a scan start or one scan bit.
// The output channel (out_valid_o/out_ready_i) carries DC, AC, end-of-block
// and error results. Configuration is a plain write port (cfg_we_i,
// cfg_index_i, cfg_data_i) with registered writes.
// Sequencing: every item goes from idle to an execute state. A magnitude bit
// that produces a result then passes through an emit state. A code bit
// then searches the selected table one entry per cycle through the single
// memory read port and comparator, so its search time grows with the number
// of entries in that table, and it goes through an emit state if it makes a result.
// The block holds one item at a time; in_ready_o is high only when idle.
// A finished result waits in the output register, and the next item is
// accepted meanwhile; if that item makes another result while the receiver
// still stalls, the sequencer waits until the output register frees up.
// Reset empties the tables, loads the default configuration and leaves the
// decoder at the start of a scan, as a start item does. There is no memory
// clearing pass: table entries are valid by their fill counts.
`include "jpeg_huffman_coefficient_decoder_macros.svh"

module jpeg_huffman_coefficient_decoder #(
  parameter int CODES_PER_TABLE = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         kind_i,
  input  logic [1:0]         table_id_i,
  input  logic [4:0]         code_length_i,
  input  logic [15:0]        code_bits_i,
  input  logic [7:0]         code_symbol_i,
  input  logic               scan_bit_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         result_kind_o,
  output logic [1:0]         component_index_o,
  output logic [3:0]         block_index_o,
  output logic [5:0]         coefficient_position_o,
  output logic [3:0]         zero_run_o,
  output logic [3:0]         magnitude_size_o,
  output logic signed [15:0] coefficient_value_o,
  output logic signed [15:0] dc_running_value_o,
  output logic [1:0]         error_code_o,
  output logic               block_done_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [5:0]         cfg_data_i
);
  import jhd_pkg::*;

  // Configuration registers.
  logic [1:0] ccount_cfg_q;
  logic [4:0] blk0_cfg_q, blk1_cfg_q, blk2_cfg_q;
  logic [5:0] tsel_q;

  // Latched input item.
  logic [1:0]  kind_q;
  logic [1:0]  tid_q;
  logic [4:0]  len_q;
  logic [15:0] bits_q;
  logic [7:0]  sym_q;
  logic        bit_q;

  // Decoder state.
  st_e                state_q, state_d;
  ph_e                phase_q, phase_d;
  logic [15:0]        acc_q, acc_d;
  logic [4:0]         seen_q, seen_d;
  logic [15:0]        mag_q, mag_d;
  logic [3:0]         left_q, left_d;
  logic [3:0]         total_q, total_d;
  logic               lead_q, lead_d;
  logic [3:0]         run_q, run_d;
  logic [6:0]         cnt_q, cnt_d;
  logic [1:0]         comp_q, comp_d;
  logic [3:0]         blk_q, blk_d;
  logic signed [15:0] pred_q [3];
  logic signed [15:0] pred_new;
  logic               pred_we;
  logic               halted_q, halted_d;
  logic               clr_pos;
  res_t               res_q, res_d;
  res_t               out_q;
  logic               out_valid_q;
  logic               out_load;

  tbl_cmd_t  tbl_cmd;
  srch_req_t srch_req;
  srch_rsp_t srch_rsp;

  // Derived values used by several branches.
  logic signed [15:0] pred_cur;
  logic [4:0]         nblk_raw, nblk;
  logic               blk_wrap, comp_wrap;
  logic [1:0]         cc_eff;
  logic [3:0]         nb_blk;
  logic [1:0]         nb_comp;
  logic               dc_tab, ac_tab;
  logic [15:0]        raw_new;
  logic               lead_new;
  logic [3:0]         left_new;
  logic [16:0]        ext_mask;
  logic [16:0]        ext_val17;
  logic signed [15:0] ext_val;
  logic signed [15:0] dc_diff;
  logic signed [17:0] dc_sum;
  logic signed [15:0] dc_sat;
  logic [6:0]         cnt_ac;
  logic [6:0]         cnt_zrl;
  logic [3:0]         sym_run, sym_size;

  function automatic logic [5:0] sat_pos(input logic [6:0] p);
    sat_pos = (p > 7'd63) ? 6'd63 : p[5:0];
  endfunction

  assign pred_cur = pred_q[comp_q];

  always_comb begin
    case (comp_q)
      2'd0:    nblk_raw = blk0_cfg_q;
      2'd1:    nblk_raw = blk1_cfg_q;
      default: nblk_raw = blk2_cfg_q;
    endcase
    case (comp_q)
      2'd0:    begin dc_tab = tsel_q[0]; ac_tab = tsel_q[1]; end
      2'd1:    begin dc_tab = tsel_q[2]; ac_tab = tsel_q[3]; end
      default: begin dc_tab = tsel_q[4]; ac_tab = tsel_q[5]; end
    endcase
  end

  assign nblk      = (nblk_raw == 5'd0) ? 5'd1 : ((nblk_raw > 5'd16) ? 5'd16 : nblk_raw);
  assign blk_wrap  = ({1'b0, blk_q} + 5'd1) >= nblk;
  assign cc_eff    = (ccount_cfg_q == 2'd0) ? 2'd1 : ccount_cfg_q;
  assign comp_wrap = (({1'b0, comp_q} + 3'd1) >= {1'b0, cc_eff}) ||
                     (({1'b0, comp_q} + 3'd1) > 3'd2);
  assign nb_blk    = blk_wrap ? 4'd0 : blk_q + 4'd1;
  assign nb_comp   = blk_wrap ? (comp_wrap ? 2'd0 : comp_q + 2'd1) : comp_q;

  // Magnitude bit and JPEG EXTEND.
  assign raw_new   = {mag_q[14:0], bit_q};
  assign lead_new  = (left_q == total_q) ? bit_q : lead_q;
  assign left_new  = left_q - 4'd1;
  assign ext_mask  = (17'd1 << total_q) - 17'd1;
  assign ext_val17 = lead_new ? {1'b0, raw_new} : ({1'b0, raw_new} - ext_mask);
  assign ext_val   = ext_val17[15:0];

  // The DC difference is zero when the size symbol is zero.
  assign dc_diff = (state_q == ST_EXEC) ? ext_val : 16'sd0;
  assign dc_sum  = 18'(pred_cur) + 18'(dc_diff);
  assign dc_sat  = (dc_sum > 18'sd32767) ? 16'sh7FFF :
                   ((dc_sum < -18'sd32768) ? 16'sh8000 : dc_sum[15:0]);

  assign cnt_ac   = cnt_q + {3'd0, run_q} + 7'd1;
  assign cnt_zrl  = cnt_q + 7'd16;
  assign sym_run  = srch_rsp.sym[7:4];
  assign sym_size = srch_rsp.sym[3:0];

  assign in_ready_o = (state_q == ST_IDLE);
  assign out_load   = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);

  // Sequencer: next state and datapath updates.
  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    acc_d    = acc_q;
    seen_d   = seen_q;
    mag_d    = mag_q;
    left_d   = left_q;
    total_d  = total_q;
    lead_d   = lead_q;
    run_d    = run_q;
    cnt_d    = cnt_q;
    comp_d   = comp_q;
    blk_d    = blk_q;
    halted_d = halted_q;
    res_d    = res_q;
    pred_we  = 1'b0;
    pred_new = dc_sat;
    clr_pos  = 1'b0;

    tbl_cmd.append = 1'b0;
    tbl_cmd.clear  = 1'b0;
    tbl_cmd.tab    = tid_q;
    tbl_cmd.len    = len_q;
    tbl_cmd.bits   = bits_q;
    tbl_cmd.sym    = sym_q;

    srch_req.start = 1'b0;
    srch_req.tab   = (phase_q == PH_DC_SYM) ? {1'b0, dc_tab} : {1'b1, ac_tab};
    srch_req.acc   = {acc_q[14:0], bit_q};
    srch_req.seen  = seen_q + 5'd1;

    // Common result fields; branches override what differs.
    res_d.comp  = comp_q;
    res_d.blk   = blk_q;
    res_d.pos   = sat_pos(cnt_q);
    res_d.run   = 4'd0;
    res_d.size  = 4'd0;
    res_d.value = 16'sd0;
    res_d.dcv   = pred_cur;
    res_d.err   = ERR_NONE;
    res_d.done  = 1'b0;
    res_d.kind  = res_q.kind;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        state_d = ST_IDLE;
        case (kind_q)
          KIND_APPEND: tbl_cmd.append = 1'b1;
          KIND_CLEAR:  tbl_cmd.clear  = 1'b1;
          KIND_START:  clr_pos        = 1'b1;
          default: begin
            if (!halted_q) begin
              if (phase_q == PH_DC_MAG || phase_q == PH_AC_MAG) begin
                mag_d  = raw_new;
                lead_d = lead_new;
                left_d = left_new;
                if (left_new == 4'd0) begin
                  state_d    = ST_EMIT;
                  res_d.size = total_q;
                  res_d.value = ext_val;
                  if (phase_q == PH_DC_MAG) begin
                    pred_we    = 1'b1;
                    res_d.kind = RK_DC;
                    res_d.pos  = 6'd0;
                    res_d.dcv  = dc_sat;
                    cnt_d      = 7'd0;
                    phase_d    = PH_AC_SYM;
                  end else begin
                    res_d.kind = RK_AC;
                    res_d.pos  = sat_pos(cnt_ac);
                    res_d.run  = run_q;
                    cnt_d      = cnt_ac;
                    phase_d    = PH_AC_SYM;
                    if (cnt_ac >= 7'(AC_COEFFICIENTS)) begin
                      res_d.done = 1'b1;
                      cnt_d      = 7'd0;
                      phase_d    = PH_DC_SYM;
                      blk_d      = nb_blk;
                      comp_d     = nb_comp;
                    end
                  end
                end
              end else begin
                acc_d          = {acc_q[14:0], bit_q};
                seen_d         = seen_q + 5'd1;
                srch_req.start = 1'b1;
                state_d        = ST_SEARCH;
              end
            end
          end
        endcase
      end

      ST_SEARCH: begin
        if (srch_rsp.done) begin
          state_d = ST_IDLE;
          if (!srch_rsp.found) begin
            if (seen_q >= 5'(MAX_CODE_LENGTH)) begin
              acc_d      = 16'd0;
              seen_d     = 5'd0;
              halted_d   = 1'b1;
              res_d.kind = RK_ERR;
              res_d.err  = ERR_NO_CODE;
              state_d    = ST_EMIT;
            end
          end else begin
            acc_d  = 16'd0;
            seen_d = 5'd0;
            if (phase_q == PH_DC_SYM) begin
              if (sym_size == 4'd0) begin
                pred_we    = 1'b1;
                res_d.kind = RK_DC;
                res_d.pos  = 6'd0;
                res_d.dcv  = dc_sat;
                cnt_d      = 7'd0;
                phase_d    = PH_AC_SYM;
                state_d    = ST_EMIT;
              end else begin
                mag_d   = 16'd0;
                left_d  = sym_size;
                total_d = sym_size;
                lead_d  = 1'b0;
                phase_d = PH_DC_MAG;
              end
            end else if (sym_size != 4'd0) begin
              run_d   = sym_run;
              mag_d   = 16'd0;
              left_d  = sym_size;
              total_d = sym_size;
              lead_d  = 1'b0;
              phase_d = PH_AC_MAG;
            end else if (sym_run == 4'd0) begin
              res_d.kind = RK_EOB;
              res_d.done = 1'b1;
              cnt_d      = 7'd0;
              phase_d    = PH_DC_SYM;
              blk_d      = nb_blk;
              comp_d     = nb_comp;
              state_d    = ST_EMIT;
            end else if (sym_run == 4'hF) begin
              cnt_d = cnt_zrl;
              if (cnt_zrl >= 7'(AC_COEFFICIENTS)) begin
                res_d.kind = RK_EOB;
                res_d.pos  = sat_pos(cnt_zrl);
                res_d.done = 1'b1;
                cnt_d      = 7'd0;
                phase_d    = PH_DC_SYM;
                blk_d      = nb_blk;
                comp_d     = nb_comp;
                state_d    = ST_EMIT;
              end
            end else begin
              halted_d   = 1'b1;
              res_d.kind = RK_ERR;
              res_d.err  = ERR_BAD_AC;
              state_d    = ST_EMIT;
            end
          end
        end
      end

      ST_EMIT: begin
        // The pending result is held unchanged until the output register takes it.
        res_d = res_q;
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    // A start item returns the decoder to the beginning of a scan.
    if (clr_pos) begin
      phase_d  = PH_DC_SYM;
      acc_d    = 16'd0;
      seen_d   = 5'd0;
      mag_d    = 16'd0;
      left_d   = 4'd0;
      total_d  = 4'd0;
      lead_d   = 1'b0;
      run_d    = 4'd0;
      cnt_d    = 7'd0;
      comp_d   = 2'd0;
      blk_d    = 4'd0;
      halted_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      phase_q      <= PH_DC_SYM;
      acc_q        <= 16'd0;
      seen_q       <= 5'd0;
      mag_q        <= 16'd0;
      left_q       <= 4'd0;
      total_q      <= 4'd0;
      lead_q       <= 1'b0;
      run_q        <= 4'd0;
      cnt_q        <= 7'd0;
      comp_q       <= 2'd0;
      blk_q        <= 4'd0;
      halted_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      ccount_cfg_q <= 2'd1;
      blk0_cfg_q   <= 5'd1;
      blk1_cfg_q   <= 5'd1;
      blk2_cfg_q   <= 5'd1;
      tsel_q       <= 6'd0;
      for (int i = 0; i < 3; i++) begin
        pred_q[i] <= 16'sd0;
      end
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      acc_q    <= acc_d;
      seen_q   <= seen_d;
      mag_q    <= mag_d;
      left_q   <= left_d;
      total_q  <= total_d;
      lead_q   <= lead_d;
      run_q    <= run_d;
      cnt_q    <= cnt_d;
      comp_q   <= comp_d;
      blk_q    <= blk_d;
      halted_q <= halted_d;
      if (clr_pos) begin
        for (int i = 0; i < 3; i++) begin
          pred_q[i] <= 16'sd0;
        end
      end else if (pred_we) begin
        pred_q[comp_q] <= pred_new;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_COMPONENT_COUNT: ccount_cfg_q <= cfg_data_i[1:0];
          CFG_BLOCKS_FIRST:    blk0_cfg_q   <= cfg_data_i[4:0];
          CFG_BLOCKS_SECOND:   blk1_cfg_q   <= cfg_data_i[4:0];
          CFG_BLOCKS_THIRD:    blk2_cfg_q   <= cfg_data_i[4:0];
          CFG_TABLE_SELECTION: tsel_q       <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Payload registers: latched item, pending result and output result.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      kind_q <= kind_i;
      tid_q  <= table_id_i;
      len_q  <= code_length_i;
      bits_q <= code_bits_i;
      sym_q  <= code_symbol_i;
      bit_q  <= scan_bit_i;
    end
    res_q <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  jhd_code_table #(
    .CODES_PER_TABLE(CODES_PER_TABLE)
  ) u_code_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (tbl_cmd),
    .req_i  (srch_req),
    .rsp_o  (srch_rsp)
  );

  assign out_valid_o            = out_valid_q;
  assign result_kind_o          = out_q.kind;
  assign component_index_o      = out_q.comp;
  assign block_index_o          = out_q.blk;
  assign coefficient_position_o = out_q.pos;
  assign zero_run_o             = out_q.run;
  assign magnitude_size_o       = out_q.size;
  assign coefficient_value_o    = out_q.value;
  assign dc_running_value_o     = out_q.dcv;
  assign error_code_o           = out_q.err;
  assign block_done_o           = out_q.done;

  `JHD_ASSERT_SAME(a_rsp_in_search, srch_rsp.done, state_q == ST_SEARCH, "search response outside search")
  `JHD_ASSERT_SAME(a_ac_count_open, phase_q == PH_AC_SYM, cnt_q < 7'd63, "AC count past end in symbol phase")
  `JHD_ASSERT_SAME(a_mag_left, phase_q == PH_DC_MAG || phase_q == PH_AC_MAG, left_q != 4'd0, "magnitude phase with no bits left")
  `JHD_ASSERT_SAME(a_comp_range, 1'b1, comp_q != 2'd3, "component index out of range")
  `JHD_ASSERT_NEXT(a_accept_exec, in_valid_i && in_ready_o, state_q == ST_EXEC, "accepted item not executed")

endmodule
